FILE: sv/ray_box_slab_intersect_macros.svh
// Assertion macros shared by the ray/box slab intersect RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`ifndef SYNTH
`define RBSI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rbsi: assertion failed");
`define RBSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsi: implication failed");
`else
`define RBSI_ASSERT(lbl, clk, rst, prop)
`define RBSI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/rbsi_pkg.sv
// Shared constants and lane result type for the ray/box slab intersect block.
package rbsi_pkg;
   // internal slab time: signed, magnitude clamped to 2^62-1
   localparam int TIME_W = 64;
   localparam logic [TIME_W-1:0] TIME_CAP = (64'd1 << 62) - 64'd1;
   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

   // what one axis lane hands to the merge stage
   typedef struct packed {
      logic signed [TIME_W-1:0] t_near;
      logic signed [TIME_W-1:0] t_far;
      logic                     miss;
   } lane_type;
endpackage

FILE: sv/ray_box_slab_intersect.sv
// Top level of the ray / axis-aligned box slab intersection test.
//
// Usage:
//   req_* takes one ray/box test per transfer: origin, direction and the two
//   box corners, twelve signed fixed-point words packed in req_tdata.
//   rsp_* returns one result per test, in order: hit in rsp_tuser and the
//   saturated entry distance in rsp_tdata (largest positive value on a miss).
//   An axis with zero direction bounds nothing when the origin lies in its
//   slab and forces a miss otherwise.
// Throughput: one test per clock while the skid register is free. Three axis
//   lanes each run two pipelined restoring dividers that retire one quotient
//   bit per stage. Path: divider input register, quotient bit stages, clamp
//   register, lane register, merge stages A and B, then the output register.
// Stall: the pipeline keeps moving while a result waits on rsp_tready; one
//   more result lands in a skid register, then req_tready drops until the
//   receiver takes data.
// Reset: synchronous, active high; clears all valid bits and empties the
//   output and skid registers. No item is accepted during reset.
`include "ray_box_slab_intersect_macros.svh"
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // entry_distance
   output logic [((COORD_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // hit
   output logic                                     rsp_tuser
);
   import rbsi_pkg::*;

   localparam int NW     = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int LAT    = NW + 5;
   localparam int OUT_DW = ((COORD_WIDTH + 7) / 8) * 8;
   localparam logic [COORD_WIDTH-1:0] ENTRY_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;

   // pipeline moves whenever the skid register is free
   assign en         = !skid_valid_ff;
   assign req_tready = !reset && en;

   // axis lanes
   lane_type lane [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_lane
      rbsi_axis_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (en),
         .origin  (signed'(req_tdata[a*COORD_WIDTH +: COORD_WIDTH])),
         .dir     (signed'(req_tdata[(3+a)*COORD_WIDTH +: COORD_WIDTH])),
         .box_min (signed'(req_tdata[(6+a)*COORD_WIDTH +: COORD_WIDTH])),
         .box_max (signed'(req_tdata[(9+a)*COORD_WIDTH +: COORD_WIDTH])),
         .lane    (lane[a])
      );
   end

   logic                          pipe_hit;
   logic signed [COORD_WIDTH-1:0] pipe_entry;

   rbsi_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
      .clock          (clock),
      .en             (en),
      .lane_x         (lane[0]),
      .lane_y         (lane[1]),
      .lane_z         (lane[2]),
      .hit            (pipe_hit),
      .entry_distance (pipe_entry)
   );

   // valid tracking alongside the datapath
   logic [LAT-1:0] vld_ff;
   logic           pipe_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   assign pipe_valid = vld_ff[LAT-1] && en;

   // output register with one skid entry
   logic                   out_hit_ff, skid_hit_ff;
   logic [COORD_WIDTH-1:0] out_entry_ff, skid_entry_ff;
   logic                   load_out, load_skid, take_skid;

   always_comb begin
      take_skid     = skid_valid_ff && rsp_tready;
      load_out      = pipe_valid && (!out_valid_ff || rsp_tready);
      load_skid     = pipe_valid && out_valid_ff && !rsp_tready;
      skid_valid_in = load_skid || (skid_valid_ff && !rsp_tready);
      out_valid_in  = pipe_valid || skid_valid_ff || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_skid) begin
         out_hit_ff   <= skid_hit_ff;
         out_entry_ff <= skid_entry_ff;
      end else if (load_out) begin
         out_hit_ff   <= pipe_hit;
         out_entry_ff <= unsigned'(pipe_entry);
      end
      if (load_skid) begin
         skid_hit_ff   <= pipe_hit;
         skid_entry_ff <= unsigned'(pipe_entry);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = OUT_DW'(out_entry_ff);

   // checks
   `RBSI_ASSERT_IMP(a_skid_has_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RBSI_ASSERT_IMP(a_skid_on_stall, clock, reset, $rose(skid_valid_ff),
      $past(rsp_tvalid && !rsp_tready))
   `RBSI_ASSERT_IMP(a_miss_entry_max, clock, reset, rsp_tvalid && !rsp_tuser,
      out_entry_ff == ENTRY_MAX)
   `RBSI_ASSERT_IMP(a_no_accept_when_full, clock, reset, skid_valid_ff, !req_tready)
endmodule

FILE: sv/rbsi_slab_div.sv
// Pipelined restoring divider: one quotient bit per stage, then clamp and sign.
module rbsi_slab_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [COORD_WIDTH:0]                mag,
   input  logic [COORD_WIDTH-1:0]              den,
   input  logic                                neg,
   output logic signed [rbsi_pkg::TIME_W-1:0]  slab_time
);
   import rbsi_pkg::*;

   localparam int MW = COORD_WIDTH + 1;
   localparam int NW = MW + FRAC_BITS;
   localparam int QX = (NW > TIME_W) ? NW : TIME_W;

   logic [NW-1:0]          num_ff [0:NW];
   logic [NW-1:0]          quo_ff [0:NW];
   logic [COORD_WIDTH-1:0] rem_ff [0:NW];
   logic [COORD_WIDTH-1:0] den_ff [0:NW];
   logic                   neg_ff [0:NW];
   logic signed [TIME_W-1:0] time_ff;

   // stage 0: dividend is the magnitude shifted up by the fraction bits
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= {mag, {FRAC_BITS{1'b0}}};
         quo_ff[0] <= '0;
         rem_ff[0] <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
      end
   end

   // one trial subtract per stage
   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [COORD_WIDTH:0] rem_sh;
      logic [COORD_WIDTH:0] rem_sub;
      logic                 take;

      always_comb begin
         rem_sh  = {rem_ff[k], num_ff[k][NW-1]};
         take    = rem_sh >= {1'b0, den_ff[k]};
         rem_sub = rem_sh - {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k+1] <= {num_ff[k][NW-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][NW-2:0], take};
            rem_ff[k+1] <= take ? rem_sub[COORD_WIDTH-1:0] : rem_sh[COORD_WIDTH-1:0];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // clamp the magnitude and apply the sign
   logic [QX-1:0]     q_ext;
   logic [TIME_W-1:0] q_mag;
   logic [TIME_W-1:0] time_in;

   always_comb begin
      q_ext   = QX'(quo_ff[NW]);
      q_mag   = (q_ext > QX'(TIME_CAP)) ? TIME_CAP : q_ext[TIME_W-1:0];
      time_in = neg_ff[NW] ? (TIME_W'(0) - q_mag) : q_mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         time_ff <= signed'(time_in);
      end
   end

   assign slab_time = time_ff;
endmodule

FILE: sv/rbsi_axis_lane.sv
// One axis lane: slab operands, two slab dividers, near/far ordering.
module rbsi_axis_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] origin,
   input  logic signed [COORD_WIDTH-1:0] dir,
   input  logic signed [COORD_WIDTH-1:0] box_min,
   input  logic signed [COORD_WIDTH-1:0] box_max,
   output rbsi_pkg::lane_type            lane
);
   import rbsi_pkg::*;

   localparam int NW      = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int DIV_LAT = NW + 2;

   logic signed [COORD_WIDTH:0] o_ext, lo_ext, hi_ext;
   logic [COORD_WIDTH:0]        mag_lo, mag_hi;
   logic [COORD_WIDTH-1:0]      den;
   logic                        neg_lo, neg_hi, par, par_miss;

   // operand prep: magnitudes and the sign of each true quotient
   always_comb begin
      o_ext    = {origin[COORD_WIDTH-1], origin};
      lo_ext   = {box_min[COORD_WIDTH-1], box_min};
      hi_ext   = {box_max[COORD_WIDTH-1], box_max};
      mag_lo   = (box_min >= origin) ? unsigned'(lo_ext - o_ext) : unsigned'(o_ext - lo_ext);
      mag_hi   = (box_max >= origin) ? unsigned'(hi_ext - o_ext) : unsigned'(o_ext - hi_ext);
      den      = dir[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - unsigned'(dir)) : unsigned'(dir);
      neg_lo   = (box_min < origin) != dir[COORD_WIDTH-1];
      neg_hi   = (box_max < origin) != dir[COORD_WIDTH-1];
      par      = (dir == '0);
      par_miss = (origin < box_min) || (origin > box_max);
   end

   logic signed [TIME_W-1:0] t1, t2;

   rbsi_slab_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock     (clock),
      .en        (en),
      .mag       (mag_lo),
      .den       (den),
      .neg       (neg_lo),
      .slab_time (t1)
   );

   rbsi_slab_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock     (clock),
      .en        (en),
      .mag       (mag_hi),
      .den       (den),
      .neg       (neg_hi),
      .slab_time (t2)
   );

   // parallel-axis flags ride alongside the dividers
   logic [1:0] flag_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff[0] <= {par, par_miss};
         for (int i = 1; i < DIV_LAT; i++) begin
            flag_ff[i] <= flag_ff[i-1];
         end
      end
   end

   // order the two slab times; a parallel axis does not bound them
   lane_type lane_in, lane_ff;

   always_comb begin
      if (flag_ff[DIV_LAT-1][1]) begin
         lane_in.t_near = TIME_MIN;
         lane_in.t_far  = TIME_MAX;
         lane_in.miss   = flag_ff[DIV_LAT-1][0];
      end else begin
         lane_in.t_near = (t1 < t2) ? t1 : t2;
         lane_in.t_far  = (t1 < t2) ? t2 : t1;
         lane_in.miss   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;
endmodule

FILE: sv/rbsi_merge.sv
// Merge of the three lanes: largest entry, smallest exit, hit and saturation.
module rbsi_merge #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  rbsi_pkg::lane_type            lane_x,
   input  rbsi_pkg::lane_type            lane_y,
   input  rbsi_pkg::lane_type            lane_z,
   output logic                          hit,
   output logic signed [COORD_WIDTH-1:0] entry_distance
);
   import rbsi_pkg::*;

   localparam logic signed [TIME_W-1:0] SAT_MAX =
      (TIME_W'(1) << (COORD_WIDTH - 1)) - TIME_W'(1);
   localparam logic signed [TIME_W-1:0] SAT_MIN = -SAT_MAX - TIME_W'(1);
   localparam logic [COORD_WIDTH-1:0]   ENTRY_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   // stage A: reduce the three lanes
   logic signed [TIME_W-1:0] near_xy, far_xy, tmin_in, tmax_in;
   logic signed [TIME_W-1:0] tmin_ff, tmax_ff;
   logic                     miss_ff;

   always_comb begin
      near_xy = (lane_x.t_near > lane_y.t_near) ? lane_x.t_near : lane_y.t_near;
      far_xy  = (lane_x.t_far  < lane_y.t_far)  ? lane_x.t_far  : lane_y.t_far;
      tmin_in = (lane_z.t_near > near_xy) ? lane_z.t_near : near_xy;
      tmax_in = (lane_z.t_far  < far_xy)  ? lane_z.t_far  : far_xy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         miss_ff <= lane_x.miss || lane_y.miss || lane_z.miss;
      end
   end

   // stage B: hit decision and entry saturation
   logic                     hit_in, hit_ff;
   logic signed [TIME_W-1:0] sat;
   logic [COORD_WIDTH-1:0]   entry_in, entry_ff;

   always_comb begin
      hit_in = !(miss_ff || (tmax_ff < 0) || (tmin_ff > tmax_ff));
      if (tmin_ff > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (tmin_ff < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = tmin_ff;
      end
      entry_in = hit_in ? sat[COORD_WIDTH-1:0] : ENTRY_MAX;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= hit_in;
         entry_ff <= entry_in;
      end
   end

   assign hit            = hit_ff;
   assign entry_distance = signed'(entry_ff);
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the ray/box slab intersection block.
module tb;
   import rbsi_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam logic signed [CW-1:0] QMAX = 32'sh7fffffff;
   localparam logic signed [CW-1:0] QMIN = 32'sh80000000;
   localparam logic signed [CW-1:0] ONE  = 32'sh00010000;
   localparam int WATCH_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 80;

   typedef logic signed [CW-1:0] coord_t;

   typedef struct packed {
      logic   hit;
      coord_t entry;
   } test_out_t;

   typedef struct {
      coord_t f [12];
      bit     typed;
      logic   hit;
      coord_t entry;
   } vec_t;

   logic           clock;
   logic           reset;
   logic           req_tvalid;
   logic           req_tready;
   logic [12*CW-1:0] req_tdata;
   logic           rsp_tvalid;
   logic           rsp_tready;
   logic [CW-1:0]  rsp_tdata;
   logic           rsp_tuser;

   ray_box_slab_intersect u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   test_out_t due_q [$];
   test_out_t typed_q [$];
   bit        typed_flag_q [$];
   int        errors;
   int        n_sent;
   int        n_hits;
   int        n_results;
   bit        req_took;
   int        idle_pct;
   int        stall_pct;
   bit        hold_req;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // slab time at internal precision, magnitude clamped
   function automatic longint slab_t(longint corner, longint org, longint dir);
      logic [63:0] mag;
      logic [63:0] den;
      logic [63:0] q;
      bit          neg;
      mag = (corner >= org) ? corner - org : org - corner;
      den = (dir < 0) ? -dir : dir;
      q   = (mag << FB) / den;
      if (q > TIME_CAP) q = TIME_CAP;
      neg = (corner < org) != (dir < 0);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic test_out_t predict_hit(logic [12*CW-1:0] d);
      longint    tmin;
      longint    tmax;
      longint    o, dr, lo, hi, t1, t2;
      bit        miss;
      test_out_t r;
      tmin = TIME_MIN;
      tmax = TIME_MAX;
      miss = 1'b0;
      for (int a = 0; a < 3; a++) begin
         o  = coord_t'(d[CW*a +: CW]);
         dr = coord_t'(d[CW*(3+a) +: CW]);
         lo = coord_t'(d[CW*(6+a) +: CW]);
         hi = coord_t'(d[CW*(9+a) +: CW]);
         if (dr == 0) begin
            if (o < lo || o > hi) miss = 1'b1;
         end else begin
            t1 = slab_t(lo, o, dr);
            t2 = slab_t(hi, o, dr);
            if ((t1 < t2 ? t1 : t2) > tmin) tmin = t1 < t2 ? t1 : t2;
            if ((t1 < t2 ? t2 : t1) < tmax) tmax = t1 < t2 ? t2 : t1;
         end
      end
      if (tmax < 0 || tmin > tmax) miss = 1'b1;
      if (miss) begin
         r.hit   = 1'b0;
         r.entry = QMAX;
      end else begin
         r.hit = 1'b1;
         if (tmin > longint'(QMAX)) r.entry = QMAX;
         else if (tmin < longint'(QMIN)) r.entry = QMIN;
         else r.entry = coord_t'(tmin);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      $display("mismatch %s: got %h want %h at result %0d", what, got, want, n_results);
      errors++;
   endtask

   // monitor: record expectations on input transfer, check on output transfer
   always @(posedge clock) begin
      test_out_t w;
      test_out_t p;
      req_took = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         req_took = 1'b1;
         p = predict_hit(req_tdata);
         if (typed_flag_q.size() != 0 && typed_flag_q.pop_front()) p = typed_q.pop_front();
         due_q.push_back(p);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_q.size() == 0) begin
            $display("unexpected result %h/%b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            w = due_q.pop_front();
            if (rsp_tuser !== w.hit) report_mismatch("hit", rsp_tuser, w.hit);
            if (rsp_tdata !== w.entry) report_mismatch("entry_distance", rsp_tdata, w.entry);
            if (rsp_tuser === 1'b1) n_hits++;
         end
         n_results++;
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) quiet = 0;
         else quiet++;
         if (quiet >= WATCH_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   // offer one test and wait for its transfer; called at a falling edge
   task automatic send_test(coord_t f [12]);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      for (int i = 0; i < 12; i++) req_tdata[CW*i +: CW] = f[i];
      req_tvalid = 1'b1;
      do @(negedge clock); while (!req_took);
      req_tvalid = 1'b0;
      n_sent++;
   endtask

   function automatic coord_t rand_word();
      return coord_t'($urandom);
   endfunction

   // mostly well-formed test: ray roughly aimed at a box of modest size
   task automatic make_aimed(output coord_t f [12]);
      coord_t c, h;
      for (int a = 0; a < 3; a++) begin
         c = coord_t'($urandom_range(200*ONE)) - 100*ONE;
         h = coord_t'($urandom_range(8*ONE));
         f[6+a] = c - h;
         f[9+a] = c + h;
         if ($urandom_range(9) == 0) begin
            f[9+a] = c - h - 1;
            f[6+a] = c + h;
         end
         f[a] = coord_t'($urandom_range(400*ONE)) - 200*ONE;
         if ($urandom_range(7) == 0) f[3+a] = '0;
         else f[3+a] = ((c - f[a]) >>> $urandom_range(2, 8))
                       + coord_t'($urandom_range(ONE)) - (ONE >>> 1);
         if ($urandom_range(9) == 0) f[a] = c + coord_t'($urandom_range(2*h)) - h;
      end
   endtask

   initial begin
      vec_t   dir_tab [$];
      vec_t   v;
      coord_t f [12];
      int     phase_idle [4];
      int     phase_stall [4];

      phase_idle = '{0, 83, 0, 38};
      phase_stall = '{0, 0, 83, 38};
      errors = 0; n_sent = 0; n_hits = 0; n_results = 0;
      idle_pct = 0; stall_pct = 0; hold_req = 1'b0; req_took = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: fields ox oy oz dx dy dz minx miny minz maxx maxy maxz
      // all axes parallel with origin inside: unbounded entry
      v.f = '{0,0,0, 0,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      v.typed = 1; v.hit = 1; v.entry = QMIN; dir_tab.push_back(v);
      // parallel axis with origin outside its slab
      v.f = '{2*ONE,0,0, 0,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      v.typed = 1; v.hit = 0; v.entry = QMAX; dir_tab.push_back(v);
      // inverted box on a parallel axis
      v.f = '{0,0,0, 0,0,0, ONE,-ONE,-ONE, -ONE,ONE,ONE};
      v.typed = 1; v.hit = 0; v.entry = QMAX; dir_tab.push_back(v);
      // plain hit along x, entry at 1.0
      v.f = '{-2*ONE,0,0, ONE,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      v.typed = 1; v.hit = 1; v.entry = ONE; dir_tab.push_back(v);
      // box behind the ray
      v.f = '{2*ONE,0,0, ONE,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      v.typed = 1; v.hit = 0; v.entry = QMAX; dir_tab.push_back(v);
      // origin inside the box: negative entry
      v.f = '{0,0,0, ONE,0,0, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      v.typed = 1; v.hit = 1; v.entry = -ONE; dir_tab.push_back(v);
      // huge time saturates the reported entry
      v.f = '{QMIN,0,0, 1,0,0, QMAX,-ONE,-ONE, QMAX,ONE,ONE};
      v.typed = 1; v.hit = 1; v.entry = QMAX; dir_tab.push_back(v);
      v.typed = 0;
      v.f = '{QMAX,0,0, QMIN,0,0, QMIN,-ONE,-ONE, QMIN,ONE,ONE}; dir_tab.push_back(v);
      v.f = '{QMIN,QMIN,QMIN, QMIN,QMIN,QMIN, QMIN,QMIN,QMIN, QMIN,QMIN,QMIN};
      dir_tab.push_back(v);
      v.f = '{QMAX,QMAX,QMAX, QMAX,QMAX,QMAX, QMAX,QMAX,QMAX, QMAX,QMAX,QMAX};
      dir_tab.push_back(v);
      v.f = '{-1,-1,-1, -1,-1,-1, QMIN,QMIN,QMIN, QMAX,QMAX,QMAX}; dir_tab.push_back(v);
      v.f = '{-4*ONE,-4*ONE,-4*ONE, ONE,ONE,ONE, -ONE,-ONE,-ONE, ONE,ONE,ONE};
      dir_tab.push_back(v);
      // diagonal that grazes an edge of the box: entry equals exit
      v.f = '{-4*ONE,0,0, ONE,ONE,0, -ONE,2*ONE,-ONE, ONE,3*ONE,ONE}; dir_tab.push_back(v);
      v.f = '{0,0,0, -ONE,-ONE,-ONE, -3*ONE,-3*ONE,-3*ONE, -ONE,-ONE,-ONE};
      dir_tab.push_back(v);
      v.f = '{ONE,0,0, ONE,0,0, ONE,-ONE,-ONE, ONE,ONE,ONE}; dir_tab.push_back(v);
      v.f = '{0,0,0, 3,-7,5, -ONE,-ONE,-ONE, ONE,ONE,ONE}; dir_tab.push_back(v);

      foreach (dir_tab[i]) begin
         typed_flag_q.push_back(dir_tab[i].typed);
         if (dir_tab[i].typed) typed_q.push_back(test_out_t'{dir_tab[i].hit, dir_tab[i].entry});
         send_test(dir_tab[i].f);
      end

      // random phases under different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phase_idle[ph];
         stall_pct = phase_stall[ph];
         if (ph == 0) hold_req = 1'b1;
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(99) < 70) make_aimed(f);
            else begin
               foreach (f[i]) f[i] = rand_word();
               if ($urandom_range(3) == 0) f[3 + $urandom_range(2)] = '0;
            end
            typed_flag_q.push_back(1'b0);
            send_test(f);
         end
      end

      idle_pct = 0;
      stall_pct = 0;
      while (due_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d ray/box tests (%0d hits) over four flow-control mixes",
               n_sent, n_hits);
      $display("including one long output hold-off that backed up the input");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+sv
sv/rbsi_pkg.sv
sv/rbsi_slab_div.sv
sv/rbsi_axis_lane.sv
sv/rbsi_merge.sv
sv/ray_box_slab_intersect.sv
sim/tb.sv
